/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bit packer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

/* rtl/lbp_pkg.sv */
// ---------------------------------------------------------------------------
// lbp_pkg
// Types, register indexes and width helpers for the LSB-first bit packer.
// ---------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

    localparam int MAX_WIDTH = 32;

    // Register indexes on the configuration channel.
    localparam logic [7:0] REG_SYMBOL_WIDTH = 8'd0;
    localparam logic [7:0] REG_WORD_WIDTH   = 8'd1;

    localparam logic [5:0] SYMBOL_WIDTH_RST = 6'd8;
    localparam logic [5:0] WORD_WIDTH_RST   = 6'd16;

    typedef struct packed {
        logic [31:0] word;
        logic [5:0]  bits;
        logic        last;
    } t_result;

    // Up to two results caused by one symbol, stored as one queue entry.
    typedef struct packed {
        t_result first;
        t_result second;
        logic    two;
    } t_pack;

    function automatic logic [5:0] f_eff_word(input logic [5:0] w);
        logic [5:0] r;
        if (w == 6'd0) begin
            r = 6'd1;
        end else if (w > 6'(MAX_WIDTH)) begin
            r = 6'(MAX_WIDTH);
        end else begin
            r = w;
        end
        return r;
    endfunction

    function automatic logic [5:0] f_eff_symbol(input logic [5:0] s, input logic [5:0] ww);
        logic [5:0] r;
        if (s == 6'd0) begin
            r = 6'd1;
        end else if (s > ww) begin
            r = ww;
        end else begin
            r = s;
        end
        return r;
    endfunction

    // Mask of the low n bits, n from 0 to 32.
    function automatic logic [31:0] f_low_mask(input logic [5:0] n);
        logic [32:0] m;
        m = (33'd1 << n) - 33'd1;
        return m[31:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/lbp_pack_core.sv */
// ---------------------------------------------------------------------------
// lbp_pack_core
// Appends one symbol above the held bits and splits off full and flush words.
// ---------------------------------------------------------------------------
`default_nettype none

module lbp_pack_core (
    input  wire logic [31:0]   i_sym,
    input  wire logic          i_fin,
    input  wire logic [30:0]   i_acc,
    input  wire logic [5:0]    i_held,
    input  wire logic [5:0]    i_sym_width,
    input  wire logic [5:0]    i_word_width,
    output lbp_pkg::t_pack     o_pack,
    output logic               o_push,
    output logic [30:0]        o_acc_next,
    output logic [5:0]         o_held_next
);
    import lbp_pkg::*;

    logic [5:0]  ww;
    logic [5:0]  sw;
    logic [5:0]  held;
    logic [31:0] sym_m;
    logic [62:0] acc_new;
    logic [62:0] shifted;
    logic [62:0] rem_acc;
    logic [5:0]  tot;
    logic [5:0]  rem_cnt;
    logic        full;
    logic        has_b;
    t_result     res_a;
    t_result     res_b;

    always_comb begin
        ww      = f_eff_word(i_word_width);
        sw      = f_eff_symbol(i_sym_width, ww);
        held    = (i_held >= ww) ? 6'd0 : i_held;
        sym_m   = i_sym & f_low_mask(sw);
        acc_new = {32'd0, i_acc} | ({31'd0, sym_m} << held);
        // held stays below ww <= 32 and sw <= ww, so the sum fits in six bits.
        tot     = held + sw;
        full    = (tot >= ww);
        shifted = acc_new >> ww;
        rem_acc = full ? shifted : acc_new;
        rem_cnt = full ? (tot - ww) : tot;
        has_b   = i_fin && (rem_cnt != 6'd0);

        res_a.word = acc_new[31:0] & f_low_mask(ww);
        res_a.bits = ww;
        res_a.last = i_fin && (rem_cnt == 6'd0);

        // Bits above rem_cnt are already zero, as the symbol was masked.
        res_b.word = rem_acc[31:0];
        res_b.bits = rem_cnt;
        res_b.last = 1'b1;

        o_pack.first  = full ? res_a : res_b;
        o_pack.second = res_b;
        o_pack.two    = full && has_b;
        o_push        = full || has_b;

        o_acc_next  = i_fin ? 31'd0 : rem_acc[30:0];
        o_held_next = i_fin ? 6'd0 : rem_cnt;
    end

endmodule

`default_nettype wire

/* rtl/lsb_first_bit_packer_unit.sv */
// Path: a symbol is held in the input register, packed by the core as it
// leaves that register, and queued in a two-entry queue that feeds the output.
// Throughput: one symbol per cycle while the queue has room and each symbol
// yields at most one word; a two-word entry leaves once both words are taken.
// Reset: synchronous, active low; clears held bits and queues, and returns
// symbol_width to 8 and word_width to 16.
// ---------------------------------------------------------------------------
// lsb_first_bit_packer_unit
// Packs narrow symbols into wider words, earliest bit in bit 0.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lsb_first_bit_packer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [5:0]  i_cfg_data,
    // Symbol input.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] symbol
    input  wire logic        i_s_axis_tlast,   // final_symbol
    // Packed word output.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [31:0] packed_word, [37:32] valid_bits
    output logic             o_m_axis_tlast    // last_word
);
    import lbp_pkg::*;

    logic [5:0]  r_sym_width;
    logic [5:0]  r_word_width;
    logic        r_in_valid;
    logic [31:0] r_sym;
    logic        r_fin;
    logic [30:0] r_acc;
    logic [5:0]  r_held;
    t_pack       r_fifo [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_fifo_cnt;
    logic        r_sel;

    logic        n_in_valid;
    logic        cfg_wr;
    logic        in_acc;
    logic        consume;
    logic        core_push;
    logic        push;
    logic        pop;
    logic        out_acc;
    t_pack       core_pack;
    t_pack       head;
    t_result     out_res;
    logic [30:0] acc_next;
    logic [5:0]  held_next;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // The input register moves on whenever the queue has room for its words.
    assign consume         = r_in_valid && (r_fifo_cnt != 2'd2);
    assign o_s_axis_tready = !r_in_valid || consume;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    lbp_pack_core u_core (
        .i_sym        (r_sym),
        .i_fin        (r_fin),
        .i_acc        (r_acc),
        .i_held       (r_held),
        .i_sym_width  (r_sym_width),
        .i_word_width (r_word_width),
        .o_pack       (core_pack),
        .o_push       (core_push),
        .o_acc_next   (acc_next),
        .o_held_next  (held_next)
    );

    assign push    = consume && core_push;
    assign head    = r_fifo[r_rd_ptr];
    assign out_res = r_sel ? head.second : head.first;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;
    // An entry leaves once its last word has been taken.
    assign pop     = out_acc && (r_sel || !head.two);

    assign o_m_axis_tvalid = (r_fifo_cnt != 2'd0);
    assign o_m_axis_tdata  = {2'd0, out_res.bits, out_res.word};
    assign o_m_axis_tlast  = out_res.last;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_acc) begin
            n_in_valid = 1'b1;
        end else if (consume) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_width  <= SYMBOL_WIDTH_RST;
            r_word_width <= WORD_WIDTH_RST;
            r_in_valid   <= 1'b0;
            r_acc        <= '0;
            r_held       <= '0;
            r_wr_ptr     <= 1'b0;
            r_rd_ptr     <= 1'b0;
            r_fifo_cnt   <= '0;
            r_sel        <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            // Any configuration request discards the held bits.
            if (cfg_wr) begin
                if (i_cfg_index == REG_SYMBOL_WIDTH) begin
                    r_sym_width <= i_cfg_data;
                end else if (i_cfg_index == REG_WORD_WIDTH) begin
                    r_word_width <= i_cfg_data;
                end
                r_acc  <= '0;
                r_held <= '0;
            end else if (consume) begin
                r_acc  <= acc_next;
                r_held <= held_next;
            end
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (out_acc) begin
                r_sel <= !pop;
            end
            r_fifo_cnt <= r_fifo_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sym <= i_s_axis_tdata;
            r_fin <= i_s_axis_tlast;
        end
        if (push) begin
            r_fifo[r_wr_ptr] <= core_pack;
        end
    end

    `ASSERT_NEVER(a_fifo_bound, i_clk, i_rst_n, r_fifo_cnt == 2'd3)
    `ASSERT_CLK(a_held_below_word, i_clk, i_rst_n, r_held < f_eff_word(r_word_width))
    `ASSERT_CLK(a_second_half_ok, i_clk, i_rst_n, r_sel |-> (o_m_axis_tvalid && head.two))
    `ASSERT_CLK(a_word_not_empty, i_clk, i_rst_n, o_m_axis_tvalid |-> (out_res.bits != 6'd0))

endmodule

`default_nettype wire
